[src/npcs_pkg.sv]
package npcs_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned MaxSearch       = 256;
  localparam int unsigned ChanW           = 16;
  localparam int unsigned IdxW            = 8;
  localparam int unsigned DistW           = 18;
  localparam int unsigned CfgW            = 9;

  localparam logic [CfgW-1:0] CellsInUseReset = CfgW'(MaxSearch);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } color_t;

  typedef struct packed {
    logic            valid;
    color_t          color;
    logic            best_valid;
    logic [DistW-1:0] best_dist;
    logic [IdxW-1:0]  best_idx;
  } token_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] index;
    color_t          color;
  } cell_wr_t;

  function automatic logic [DistW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return DistW'(d);
  endfunction

endpackage

[src/npcs_in_if.sv]
interface npcs_in_if;
  import npcs_pkg::*;

  logic            valid;
  logic            ready;
  logic            cmd;
  logic [IdxW-1:0]  cell_index;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, cmd, cell_index, red, green, blue, input ready);
  modport sink   (input valid, cmd, cell_index, red, green, blue, output ready);
endinterface

[src/npcs_out_if.sv]
interface npcs_out_if;
  import npcs_pkg::*;

  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  nearest_index;
  logic [DistW-1:0] distance;

  modport source (output valid, nearest_index, distance, input ready);
  modport sink   (input valid, nearest_index, distance, output ready);
endinterface

[src/npcs_cell.sv]
module npcs_cell #(
  parameter int unsigned CellId = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  npcs_pkg::cell_wr_t         wr_i,
  input  logic [npcs_pkg::CfgW-1:0]  search_len_i,
  input  npcs_pkg::token_t           tok_i,
  output npcs_pkg::token_t           tok_o
);
  import npcs_pkg::*;

  localparam logic [CfgW-1:0] Id = CfgW'(CellId);

  logic             entry_valid_q;
  color_t           color_q;
  color_t           color_rd;
  logic             wr_hit;
  logic [DistW-1:0] cell_dist;
  logic             take;
  token_t           tok_d;
  token_t           tok_q;

  assign wr_hit   = wr_i.en && (wr_i.index == Id[IdxW-1:0]);
  assign color_rd = entry_valid_q ? color_q : '0;

  assign cell_dist = abs_diff(tok_i.color.red, color_rd.red)
                   + abs_diff(tok_i.color.green, color_rd.green)
                   + abs_diff(tok_i.color.blue, color_rd.blue);

  assign take = tok_i.valid && (Id < search_len_i)
             && (!tok_i.best_valid || (cell_dist < tok_i.best_dist));

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.best_valid = 1'b1;
      tok_d.best_dist  = cell_dist;
      tok_d.best_idx   = Id[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
      tok_q         <= '0;
    end else begin
      if (wr_hit) begin
        entry_valid_q <= 1'b1;
      end
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      color_q <= wr_i.color;
    end
  end

  assign tok_o = tok_q;

endmodule

[src/nearest_palette_colour_search_core.sv]
// Nearest palette color search. The palette lives in a row of cells, one
// entry per cell, min(PALETTE_DEPTH, 256) cells long. A write beat loads one
// cell and gives no result. A query beat enters the first cell and moves
// one cell per cycle, each cell below the search length comparing its own
// distance with the best so far, so the result passes through every cell of
// the row, independent of cells_in_use, and then into a pending register.
// One item is in work at a time: input is taken again once the result has
// moved into the output register, where it may wait for the sink. Cells read
// as black until written after reset.
module nearest_palette_colour_search_core #(
  parameter int unsigned PALETTE_DEPTH = npcs_pkg::PaletteDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [npcs_pkg::CfgW-1:0] cfg_wdata_i,
  npcs_in_if.sink                   in_i,
  npcs_out_if.source                out_o
);
  import npcs_pkg::*;

  localparam int unsigned NCells = (PALETTE_DEPTH < MaxSearch) ? PALETTE_DEPTH : MaxSearch;
  localparam logic [CfgW-1:0] NCellsLen = CfgW'(NCells);

  logic [CfgW-1:0]  cells_in_use_q;
  logic [CfgW-1:0]  search_len;
  logic             busy_q;
  logic             in_acc;
  logic             is_query;
  cell_wr_t         wr;
  token_t           tok [NCells+1];
  logic [NCells-1:0] tok_vld;
  logic             pend_valid_q;
  logic [IdxW-1:0]  pend_idx_q;
  logic [DistW-1:0] pend_dist_q;
  logic             out_valid_q;
  logic [IdxW-1:0]  out_idx_q;
  logic [DistW-1:0] out_dist_q;
  logic             move;

  always_comb begin
    search_len = cells_in_use_q;
    if (search_len == '0) begin
      search_len = CfgW'(1);
    end
    if (search_len > NCellsLen) begin
      search_len = NCellsLen;
    end
  end

  assign in_i.ready = !busy_q;
  assign in_acc     = in_i.valid && !busy_q;
  assign is_query   = (cmd_e'(in_i.cmd) == CMD_QUERY);

  assign wr.en          = in_acc && !is_query;
  assign wr.index       = in_i.cell_index;
  assign wr.color.red   = in_i.red;
  assign wr.color.green = in_i.green;
  assign wr.color.blue  = in_i.blue;

  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = in_acc && is_query;
    tok[0].color      = wr.color;
    tok[0].best_valid = 1'b0;
  end

  for (genvar j = 0; j < NCells; j++) begin : g_cell
    npcs_cell #(
      .CellId(j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_i        (wr),
      .search_len_i(search_len),
      .tok_i       (tok[j]),
      .tok_o       (tok[j+1])
    );
    assign tok_vld[j] = tok[j+1].valid;
  end

  assign move = pend_valid_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_in_use_q <= CellsInUseReset;
      busy_q         <= 1'b0;
      pend_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cells_in_use_q <= cfg_wdata_i;
      end
      if (in_acc && is_query) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (tok[NCells].valid) begin
        pend_valid_q <= 1'b1;
      end else if (move) begin
        pend_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[NCells].valid) begin
      pend_idx_q  <= tok[NCells].best_idx;
      pend_dist_q <= tok[NCells].best_dist;
    end
    if (move) begin
      out_idx_q  <= pend_idx_q;
      out_dist_q <= pend_dist_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.nearest_index = out_idx_q;
  assign out_o.distance      = out_dist_q;

  a_one_query_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one query in the cell row");

  a_tail_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NCells].valid |-> (!pend_valid_q && busy_q))
    else $error("query result arrived while pending result still held");

  a_query_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_query) |=> (busy_q && tok[1].valid))
    else $error("accepted query did not enter the cell row");

  a_pend_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> busy_q)
    else $error("pending result held while input is open");

endmodule
